// ===== sv/two_level_page_table_map_translate_core_defines.svh =====
// assertion macros shared by the checker
`ifndef TWO_LEVEL_PAGE_TABLE_MAP_TRANSLATE_CORE_DEFINES_SVH
`define TWO_LEVEL_PAGE_TABLE_MAP_TRANSLATE_CORE_DEFINES_SVH

// same-cycle implication
`define TLPTMT_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define TLPTMT_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== sv/tlptmt_pkg.sv =====
package tlptmt_pkg;

	localparam int FUNC_W    = 2;
	localparam int ADDR_W    = 32;
	localparam int FLAGS_W   = 12;
	localparam int STATUS_W  = 2;
	localparam int DIR_DEPTH = 1024;
	localparam int DIR_AW    = 10;
	localparam int TBL_ENTRIES = 1024;
	localparam int TBL_IDX_W = 10;
	localparam int DEF_TABLE_SLOTS = 16;

	// request codes
	localparam logic [FUNC_W-1:0] FUNC_MAP   = 2'd0;
	localparam logic [FUNC_W-1:0] FUNC_UNMAP = 2'd1;
	localparam logic [FUNC_W-1:0] FUNC_XLATE = 2'd2;
	localparam logic [FUNC_W-1:0] FUNC_RSVD  = 2'd3;

	// result codes
	localparam logic [STATUS_W-1:0] STATUS_OK   = 2'd0;
	localparam logic [STATUS_W-1:0] STATUS_MISS = 2'd1;
	localparam logic [STATUS_W-1:0] STATUS_FULL = 2'd2;

	localparam logic [FLAGS_W-1:0] FLAG_PRESENT = 12'h001;

endpackage

// ===== sv/tlptmt_if.sv =====
interface tlptmt_req_if;
	import tlptmt_pkg::*;

	logic                valid;
	logic                ready;
	logic [FUNC_W-1:0]   func;
	logic [ADDR_W-1:0]   virt_addr;
	logic [ADDR_W-1:0]   map_addr;
	logic [FLAGS_W-1:0]  page_flags;

	modport source (output valid, func, virt_addr, map_addr, page_flags, input ready);
	modport sink   (input valid, func, virt_addr, map_addr, page_flags, output ready);
endinterface

interface tlptmt_rsp_if;
	import tlptmt_pkg::*;

	logic                valid;
	logic                ready;
	logic [STATUS_W-1:0] status;
	logic [ADDR_W-1:0]   phys_out;

	modport source (output valid, status, phys_out, input ready);
	modport sink   (input valid, status, phys_out, output ready);
endinterface

// ===== sv/tlptmt_ram.sv =====
module tlptmt_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 1024,
	localparam int AW = $clog2(DEPTH)
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// registered read, holds when re is low
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// ===== sv/two_level_page_table_map_translate_core.sv =====
// Two-level page table engine. A request's virtual address bits 31:22 select a directory
// entry and bits 21:12 an entry of a second-level table; tables come from a pool of
// TABLE_SLOTS slots handed out in order and never returned. Map allocates a table when
// the directory entry is absent (status 2 when the pool is used up) and writes the frame
// bits with the flags and present; unmap clears the entry (status 1 without a table);
// translate returns frame plus offset or status 1. One request is worked at a time: map
// and unmap finish after the synchronous directory read, translate after the dependent
// table read as well, each only once the output register has room. A finished result
// waits in an output register while the next request is taken. After reset a clearing
// pass writes zero through the whole table memory (and the directory alongside), with
// req.ready held low until it ends.
module two_level_page_table_map_translate_core #(
	parameter int TABLE_SLOTS = tlptmt_pkg::DEF_TABLE_SLOTS
) (
	input logic         clk,
	input logic         arst_n,
	tlptmt_req_if.sink  req,
	tlptmt_rsp_if.source rsp
);
	import tlptmt_pkg::*;

	// slot index, allocation counter and table memory geometry
	localparam int SLOT_W    = (TABLE_SLOTS > 1) ? $clog2(TABLE_SLOTS) : 1;
	localparam int CNT_W     = $clog2(TABLE_SLOTS + 1);
	localparam int TBL_DEPTH = TABLE_SLOTS * TBL_ENTRIES;
	localparam int TBL_AW    = $clog2(TBL_DEPTH);
	localparam int DIR_W     = SLOT_W + 1;

	// sequencer states
	localparam logic [1:0] ST_CLEAR = 2'd0;
	localparam logic [1:0] ST_IDLE  = 2'd1;
	localparam logic [1:0] ST_DIR   = 2'd2;
	localparam logic [1:0] ST_TBL   = 2'd3;

	logic [1:0]         state_q, state_d;
	logic [TBL_AW-1:0]  clr_cnt_q;
	logic [CNT_W-1:0]   next_free_q;

	// captured request
	logic [FUNC_W-1:0]  func_q;
	logic [ADDR_W-1:0]  va_q;
	logic [ADDR_W-1:0]  pa_q;
	logic [FLAGS_W-1:0] flags_q;

	// output register
	logic                out_valid_q;
	logic [STATUS_W-1:0] status_q;
	logic [ADDR_W-1:0]   phys_q;

	// memory ports
	logic              dir_we, dir_re;
	logic [DIR_AW-1:0] dir_waddr, dir_raddr;
	logic [DIR_W-1:0]  dir_wdata, dir_rdata;
	logic              tbl_we, tbl_re;
	logic [TBL_AW-1:0] tbl_waddr, tbl_addr;
	logic [ADDR_W-1:0] tbl_wdata, tbl_rdata;

	logic                req_acc, out_free, fin, alloc, pool_full, dir_valid, clr_last;
	logic [SLOT_W-1:0]   dir_slot, eff_slot;
	logic [STATUS_W-1:0] fin_status;
	logic [ADDR_W-1:0]   fin_phys;

	assign req.ready = (state_q == ST_IDLE);
	assign req_acc   = req.valid && req.ready;
	assign rsp.valid    = out_valid_q;
	assign rsp.status   = status_q;
	assign rsp.phys_out = phys_q;

	// the output register can take a result this cycle
	assign out_free = !out_valid_q || rsp.ready;

	// directory word: present flag over the table slot
	assign dir_valid = dir_rdata[SLOT_W];
	assign dir_slot  = dir_rdata[SLOT_W-1:0];
	assign pool_full = (next_free_q == CNT_W'(TABLE_SLOTS));
	// a fresh slot is used when the directory entry is absent
	assign eff_slot  = dir_valid ? dir_slot : SLOT_W'(next_free_q);
	assign tbl_addr  = TBL_AW'({eff_slot, va_q[21:12]});
	assign clr_last  = (clr_cnt_q == TBL_AW'(TBL_DEPTH - 1));

	// directory read is issued straight from the request at accept
	assign dir_re    = req_acc;
	assign dir_raddr = req.virt_addr[31:22];

	always_comb begin
		state_d    = state_q;
		dir_we     = 1'b0;
		dir_waddr  = va_q[31:22];
		dir_wdata  = {1'b1, eff_slot};
		tbl_we     = 1'b0;
		tbl_waddr  = tbl_addr;
		tbl_wdata  = {pa_q[31:12], flags_q | FLAG_PRESENT};
		tbl_re     = 1'b0;
		fin        = 1'b0;
		alloc      = 1'b0;
		fin_status = STATUS_OK;
		fin_phys   = '0;
		unique case (state_q)
			ST_CLEAR: begin
				// zero both stores; the directory is swept repeatedly, which is harmless
				dir_we    = 1'b1;
				dir_waddr = clr_cnt_q[DIR_AW-1:0];
				dir_wdata = '0;
				tbl_we    = 1'b1;
				tbl_waddr = clr_cnt_q;
				tbl_wdata = '0;
				if (clr_last) begin
					state_d = ST_IDLE;
				end
			end
			ST_IDLE: begin
				if (req_acc) begin
					state_d = ST_DIR;
				end
			end
			ST_DIR: begin
				// directory word is valid here; writes happen only when the result can leave
				if (out_free) begin
					case (func_q) inside
						FUNC_MAP: begin
							fin = 1'b1;
							if (!dir_valid && pool_full) begin
								fin_status = STATUS_FULL;
							end else begin
								tbl_we = 1'b1;
								if (!dir_valid) begin
									dir_we = 1'b1;
									alloc  = 1'b1;
								end
							end
						end
						FUNC_UNMAP: begin
							fin = 1'b1;
							if (!dir_valid) begin
								fin_status = STATUS_MISS;
							end else begin
								tbl_we    = 1'b1;
								tbl_wdata = '0;
							end
						end
						FUNC_XLATE, FUNC_RSVD: begin
							if (!dir_valid) begin
								fin        = 1'b1;
								fin_status = STATUS_MISS;
							end else begin
								tbl_re  = 1'b1;
								state_d = ST_TBL;
							end
						end
						default: begin
							fin = 1'b1;
						end
					endcase
					if (fin) begin
						state_d = ST_IDLE;
					end
				end
			end
			ST_TBL: begin
				// table entry is valid here and held until the result leaves
				if (out_free) begin
					fin     = 1'b1;
					state_d = ST_IDLE;
					if (!tbl_rdata[0]) begin
						fin_status = STATUS_MISS;
					end else begin
						fin_phys = {tbl_rdata[31:12], va_q[11:0]};
					end
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLEAR;
			clr_cnt_q   <= '0;
			next_free_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == ST_CLEAR) begin
				clr_cnt_q <= clr_cnt_q + 1'b1;
			end
			if (alloc) begin
				next_free_q <= next_free_q + 1'b1;
			end
			if (fin) begin
				out_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (req_acc) begin
			func_q  <= req.func;
			va_q    <= req.virt_addr;
			pa_q    <= req.map_addr;
			flags_q <= req.page_flags;
		end
		if (fin) begin
			status_q <= fin_status;
			phys_q   <= fin_phys;
		end
	end

	// directory: present flag plus table slot per entry
	tlptmt_ram #(
		.WIDTH (DIR_W),
		.DEPTH (DIR_DEPTH)
	) u_dir_ram (
		.clk   (clk),
		.we    (dir_we),
		.waddr (dir_waddr),
		.wdata (dir_wdata),
		.re    (dir_re),
		.raddr (dir_raddr),
		.rdata (dir_rdata)
	);

	// second-level tables, one 1024-word block per slot
	tlptmt_ram #(
		.WIDTH (ADDR_W),
		.DEPTH (TBL_DEPTH)
	) u_tbl_ram (
		.clk   (clk),
		.we    (tbl_we),
		.waddr (tbl_waddr),
		.wdata (tbl_wdata),
		.re    (tbl_re),
		.raddr (tbl_addr),
		.rdata (tbl_rdata)
	);

endmodule

// ===== sv/tlptmt_chk.sv =====
`include "two_level_page_table_map_translate_core_defines.svh"

module tlptmt_chk (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          req_valid,
	input logic                          req_ready,
	input logic                          rsp_valid,
	input logic                          rsp_ready,
	input logic [tlptmt_pkg::STATUS_W-1:0] rsp_status,
	input logic [tlptmt_pkg::ADDR_W-1:0]   rsp_phys_out
);
	import tlptmt_pkg::*;

	// items taken but not yet delivered
	logic [1:0] pend_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q <= '0;
		end else begin
			pend_q <= pend_q + 2'(req_valid && req_ready) - 2'(rsp_valid && rsp_ready);
		end
	end

	`TLPTMT_ASSERT_NOW(a_no_orphan_result, clk, arst_n, rsp_valid, pend_q != 2'd0, "result without item")
	`TLPTMT_ASSERT_NOW(a_pend_bound, clk, arst_n, 1'b1, pend_q != 2'd3, "too many items in flight")
	`TLPTMT_ASSERT_NOW(a_miss_zero, clk, arst_n, rsp_valid && (rsp_status != STATUS_OK), rsp_phys_out == '0, "address on failed result")
	`TLPTMT_ASSERT_NEXT(a_rsp_hold, clk, arst_n, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_status) && $stable(rsp_phys_out), "stalled result changed")

endmodule

bind two_level_page_table_map_translate_core tlptmt_chk u_chk (
	.clk          (clk),
	.arst_n       (arst_n),
	.req_valid    (req.valid),
	.req_ready    (req.ready),
	.rsp_valid    (rsp.valid),
	.rsp_ready    (rsp.ready),
	.rsp_status   (rsp.status),
	.rsp_phys_out (rsp.phys_out)
);

// ===== verif/testbench.sv =====
`timescale 1ns / 100ps

module testbench;
	import tlptmt_pkg::*;

	// block configuration and run limits
	localparam int TABLE_SLOTS = DEF_TABLE_SLOTS;
	// the clearing pass after reset alone keeps the input closed while it sweeps the table memory
	localparam int QUIET_LIMIT = TABLE_SLOTS * TBL_ENTRIES * 3 + 5000;
	localparam int DRAIN_CYCLES = 20;
	localparam int STALL_CYCLES = 300;

	// one response as the page walk predicts it
	typedef struct packed {
		logic [STATUS_W-1:0] status;
		logic [ADDR_W-1:0]   phys;
	} walk_result_t;

	logic clk;
	logic arst_n;

	tlptmt_req_if req();
	tlptmt_rsp_if rsp();

	two_level_page_table_map_translate_core #(
		.TABLE_SLOTS(TABLE_SLOTS)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.req(req),
		.rsp(rsp)
	);

	// shadow copy of the page table
	bit              dir_present [DIR_DEPTH];
	int              dir_slot    [DIR_DEPTH];
	bit [ADDR_W-1:0] tbl_word    [TABLE_SLOTS * TBL_ENTRIES];
	int              slots_used;

	// responses predicted but not yet seen
	walk_result_t pending_walks[$];

	// idling percentages and receiver hold-off request
	int snd_idle_pct;
	int rcv_idle_pct;
	int rsp_hold_req;

	int mismatch_cnt;

	// directories that own the whole table pool, and hot second-level indexes
	logic [DIR_AW-1:0]    pool_dir [TABLE_SLOTS];
	logic [DIR_AW-1:0]    spill_dir;
	logic [TBL_IDX_W-1:0] hot_tbl  [8];

	// 10 ns clock
	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// page walk: updates the shadow table and returns the expected response
	function automatic walk_result_t walk_page_table(logic [FUNC_W-1:0] fn,
			logic [ADDR_W-1:0] va, logic [ADDR_W-1:0] pa, logic [FLAGS_W-1:0] flags);
		walk_result_t    r;
		int unsigned     dir;
		int unsigned     idx;
		logic [ADDR_W-1:0] entry;
		r.status = STATUS_OK;
		r.phys   = '0;
		dir      = va[31:22];
		case (fn)
			FUNC_MAP: begin
				// absent directory entry takes the next table from the pool
				if (!dir_present[dir]) begin
					if (slots_used >= TABLE_SLOTS) begin
						r.status = STATUS_FULL;
					end else begin
						dir_present[dir] = 1'b1;
						dir_slot[dir]    = slots_used;
						slots_used++;
					end
				end
				if (r.status == STATUS_OK) begin
					idx = dir_slot[dir] * TBL_ENTRIES + va[21:12];
					tbl_word[idx] = {pa[31:12], flags | FLAG_PRESENT};
				end
			end
			FUNC_UNMAP: begin
				// entry is cleared whether or not it was present, if the directory entry holds a table
				if (!dir_present[dir]) begin
					r.status = STATUS_MISS;
				end else begin
					idx = dir_slot[dir] * TBL_ENTRIES + va[21:12];
					tbl_word[idx] = '0;
				end
			end
			default: begin
				// translate; the unused code decodes the same way
				if (!dir_present[dir]) begin
					r.status = STATUS_MISS;
				end else begin
					idx   = dir_slot[dir] * TBL_ENTRIES + va[21:12];
					entry = tbl_word[idx];
					if ((entry[FLAGS_W-1:0] & FLAG_PRESENT) == '0) begin
						r.status = STATUS_MISS;
					end else begin
						r.phys = {entry[31:12], va[11:0]};
					end
				end
			end
		endcase
		return r;
	endfunction

	function automatic bit dir_taken(logic [DIR_AW-1:0] cand, int n);
		for (int k = 0; k < n; k++) begin
			if (pool_dir[k] == cand) return 1'b1;
		end
		return 1'b0;
	endfunction

	// drive one item at the falling edge and hold it until accepted;
	// entered and left at a falling edge
	task automatic send_request(logic [FUNC_W-1:0] fn, logic [ADDR_W-1:0] va,
			logic [ADDR_W-1:0] pa, logic [FLAGS_W-1:0] flags);
		while ($urandom_range(99) < snd_idle_pct) begin
			req.valid <= 1'b0;
			@(negedge clk);
		end
		req.valid      <= 1'b1;
		req.func       <= fn;
		req.virt_addr  <= va;
		req.map_addr   <= pa;
		req.page_flags <= flags;
		do @(posedge clk); while (!req.ready);
		pending_walks.push_back(walk_page_table(fn, va, pa, flags));
		@(negedge clk);
	endtask

	// random item: mostly the allocated directories and a few hot entries,
	// so that maps, remaps, hits and misses pile onto the same words
	task automatic send_random_request();
		int unsigned          pick;
		logic [FUNC_W-1:0]    fn;
		logic [DIR_AW-1:0]    dir;
		logic [TBL_IDX_W-1:0] tix;
		pick = $urandom_range(99);
		if (pick < 40) fn = FUNC_MAP;
		else if (pick < 55) fn = FUNC_UNMAP;
		else if (pick < 95) fn = FUNC_XLATE;
		else fn = FUNC_RSVD;
		if ($urandom_range(99) < 85) dir = pool_dir[$urandom_range(TABLE_SLOTS - 1)];
		else dir = DIR_AW'($urandom_range(DIR_DEPTH - 1));
		if ($urandom_range(99) < 80) tix = hot_tbl[$urandom_range(7)];
		else tix = TBL_IDX_W'($urandom_range(TBL_ENTRIES - 1));
		send_request(fn, {dir, tix, 12'($urandom_range(4095))}, $urandom,
			FLAGS_W'($urandom_range(4095)));
	endtask

	task automatic note_mismatch(string what, logic [ADDR_W-1:0] expv, logic [ADDR_W-1:0] actv);
		mismatch_cnt++;
		if (mismatch_cnt <= 10)
			$display("%0t mismatch %s: expected %h actual %h", $realtime, what, expv, actv);
	endtask

	// hand-picked requests on directory 0: no table, first allocation,
	// forced present bit, extremes of frame, flags and offset, remap, unmap
	task automatic run_basic_ops();
		send_request(FUNC_UNMAP, 32'h0000_0000, 32'h0, 12'h000);        // unmap, no table yet
		send_request(FUNC_MAP,   32'h0000_0000, 32'hFFFF_FFFF, 12'h000); // allocates slot 0
		send_request(FUNC_XLATE, 32'h0000_0FFF, 32'h0, 12'h000);        // hit, top offset
		send_request(FUNC_UNMAP, 32'h0000_1000, 32'h0, 12'h000);        // clear never-mapped entry
		send_request(FUNC_XLATE, 32'h0000_1000, 32'h0, 12'h000);        // miss, not present
		send_request(FUNC_MAP,   32'h003F_F000, 32'h0000_0FFF, 12'hFFF); // last entry, zero frame
		send_request(FUNC_RSVD,  32'h003F_F123, 32'h0, 12'h000);        // unused code translates
		send_request(FUNC_MAP,   32'h0000_0ABC, 32'h1234_5678, 12'h006); // remap over present entry
		send_request(FUNC_XLATE, 32'h0000_0ABC, 32'h0, 12'h000);
		send_request(FUNC_UNMAP, 32'h0000_0000, 32'h0, 12'h000);
		send_request(FUNC_XLATE, 32'h0000_0000, 32'h0, 12'h000);        // miss after unmap
	endtask

	// use up the remaining slots, then one more directory must be refused
	task automatic run_pool_exhaustion();
		for (int k = 1; k < TABLE_SLOTS; k++) begin
			send_request(FUNC_MAP,
				{pool_dir[k], TBL_IDX_W'($urandom_range(TBL_ENTRIES - 1)), 12'($urandom_range(4095))},
				$urandom, FLAGS_W'($urandom_range(4095)));
		end
		send_request(FUNC_MAP, {spill_dir, 22'h2A_5A5}, 32'hDEAD_B000, 12'h003);
		send_request(FUNC_XLATE, {spill_dir, 22'h2A_5A5}, 32'h0, 12'h000);
	endtask

	task automatic run_random_traffic(int n);
		repeat (n) send_random_request();
	endtask

	// receiver holds off while the sender keeps offering, so the block backs up
	task automatic run_output_stall();
		@(posedge clk);
		rsp_hold_req = STALL_CYCLES;
		@(negedge clk);
		repeat (40) send_random_request();
	endtask

	// response ready: random stalls plus the long hold-off on request
	initial begin
		int hold_left;
		hold_left = 0;
		rsp.ready = 1'b0;
		forever begin
			@(negedge clk);
			if (rsp_hold_req > 0) begin
				hold_left    = rsp_hold_req;
				rsp_hold_req = 0;
			end
			if (hold_left > 0) begin
				hold_left--;
				rsp.ready <= 1'b0;
			end else begin
				rsp.ready <= ($urandom_range(99) >= rcv_idle_pct);
			end
		end
	end

	// compare each accepted response with the oldest prediction
	always @(posedge clk) begin
		walk_result_t want;
		if (rsp.valid && rsp.ready) begin
			if (pending_walks.size() == 0) begin
				note_mismatch("response with no request outstanding", '0, rsp.phys_out);
			end else begin
				want = pending_walks.pop_front();
				if (rsp.status !== want.status)
					note_mismatch("status", ADDR_W'(want.status), ADDR_W'(rsp.status));
				if (rsp.phys_out !== want.phys)
					note_mismatch("phys_out", want.phys, rsp.phys_out);
			end
		end
	end

	// watchdog on cycles with no item moving on either side
	initial begin
		int quiet;
		quiet = 0;
		@(posedge arst_n);
		while (quiet < QUIET_LIMIT) begin
			@(posedge clk);
			if ((req.valid && req.ready) || (rsp.valid && rsp.ready)) quiet = 0;
			else quiet++;
		end
		$display("testbench: errors");
		$finish;
	end

	initial begin
		logic [DIR_AW-1:0] cand;
		// known values on every input from time zero
		arst_n         = 1'b0;
		req.valid      = 1'b0;
		req.func       = FUNC_MAP;
		req.virt_addr  = '0;
		req.map_addr   = '0;
		req.page_flags = '0;
		snd_idle_pct   = 29;
		rcv_idle_pct   = 56;
		rsp_hold_req   = 0;
		mismatch_cnt   = 0;
		slots_used     = 0;
		for (int d = 0; d < DIR_DEPTH; d++) begin
			dir_present[d] = 1'b0;
			dir_slot[d]    = 0;
		end
		for (int w = 0; w < TABLE_SLOTS * TBL_ENTRIES; w++) tbl_word[w] = '0;

		// directories that will own the pool: both ends plus random ones
		pool_dir[0] = '0;
		pool_dir[1] = '1;
		for (int k = 2; k < TABLE_SLOTS; k++) begin
			do cand = DIR_AW'($urandom_range(DIR_DEPTH - 2, 1)); while (dir_taken(cand, k));
			pool_dir[k] = cand;
		end
		do cand = DIR_AW'($urandom_range(DIR_DEPTH - 1)); while (dir_taken(cand, TABLE_SLOTS));
		spill_dir = cand;
		hot_tbl[0] = '0;
		hot_tbl[1] = '1;
		for (int k = 2; k < 8; k++) hot_tbl[k] = TBL_IDX_W'($urandom_range(TBL_ENTRIES - 1));

		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// sender idles less than the receiver
		run_basic_ops();
		run_pool_exhaustion();
		run_random_traffic(450);
		run_output_stall();

		// receiver idles less than the sender
		snd_idle_pct = 56;
		rcv_idle_pct = 29;
		run_random_traffic(500);

		// back to back on both sides
		snd_idle_pct = 0;
		rcv_idle_pct = 0;
		run_random_traffic(500);
		req.valid <= 1'b0;

		while (pending_walks.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (mismatch_cnt == 0 && pending_walks.size() == 0) begin
			$display("testbench: clean");
		end else begin
			$display("testbench: errors");
		end
		$finish;
	end

endmodule
